### rtl/core/ccd_pkg.sv
// Shared types, constants and helper functions for the crank cadence display.
// Used by ccd_div and crank_cadence_display; depends on nothing else.
`default_nettype none

package ccd_pkg;

    // Numerator width: 60 * 16-bit units/s (22 bits) times a 16-bit count delta
    localparam int unsigned SCALE_W = 22;
    localparam int unsigned NUM_W   = 38;

    localparam logic [7:0] CHR_DASH  = 8'h2D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;

    localparam logic [15:0] TUPS_RESET    = 16'd1000;
    localparam logic [9:0]  MAX_CAD_RESET = 10'd200;
    localparam logic [15:0] STALE_RESET   = 16'd5000;
    localparam logic [15:0] CADENCE_RESET = 16'd999;
    localparam logic [15:0] CADENCE_SAT   = 16'hFFFF;
    localparam logic [15:0] MS_SAT        = 16'hFFFF;
    localparam logic [15:0] HUNDRED       = 16'd100;

    // floor(v / 10) == (v * 0xCCCD) >> 19 for every 16-bit v
    localparam logic [15:0] DIV10_MUL = 16'hCCCD;

    typedef enum logic [1:0] {
        CMD_MEAS = 2'd0,
        CMD_TICK = 2'd1,
        CMD_LINK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_TUPS    = 2'd0,
        CFG_MAX_CAD = 2'd1,
        CFG_STALE   = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [12:0] div10(input logic [15:0] v);
        logic [31:0] p;
        p = v * DIV10_MUL;
        return p[31:19];
    endfunction

    // Remainder digit from the low nibbles of a value and of its quotient by ten
    function automatic logic [3:0] rem10(input logic [3:0] v, input logic [3:0] q);
        logic [3:0] tq;
        tq = {q[0], 3'b000} + {q[2:0], 1'b0};
        return v - tq;
    endfunction

endpackage

`default_nettype wire

### rtl/core/crank_cadence_display.sv
// Crank cadence display: one input word in, one three-character result word out.
// A crank measurement that changes the count passes two multiply steps, divider start,
// 16 divider iterations, done, three divide-by-ten steps and output load, without the
// iterations when the quotient saturates; every other word skips to the divide-by-ten
// steps. A waiting result stalls the load. No word is taken while one is in flight.
// Reset (rst_n, async low) restores the register defaults and cadence 999, link down.
`default_nettype none

module crank_cadence_display (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // rev_count[15:0], event_time[31:16], link_up[32], zero
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // char_hundreds[7:0], char_tens[15:8],
                                        // char_units[23:16], cadence_rpm[39:24]
    output logic             m_tuser,   // showing_dashes
    // register write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import ccd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_WAIT,
        ST_DIG_A,
        ST_DIG_B,
        ST_DIG_C,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] tups_reg;
    logic [9:0]  max_cad_reg;
    logic [15:0] stale_reg;

    // tracked state
    logic [15:0] last_count_reg;
    logic [15:0] last_time_reg;
    logic [15:0] cadence_reg;
    logic [15:0] ms_reg;
    logic        link_reg;

    // work registers
    logic [15:0]        dc_reg;
    logic [15:0]        dt_reg;
    logic [SCALE_W-1:0] scaled_reg;
    logic [NUM_W-1:0]   num_reg;
    logic               div_start_reg;
    logic [12:0]        qa_reg;
    logic [9:0]         qb_reg;
    logic [6:0]         qc_reg;

    // output register
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic [15:0] div_quot;
    div_stat_t   div_stat;

    cmd_t        in_cmd;
    logic [15:0] in_rev;
    logic [15:0] in_time;
    logic        in_link;
    logic        in_acc;

    logic [15:0] d10_in;
    logic [12:0] d10_out;

    logic [3:0]  dig_u;
    logic [3:0]  dig_t;
    logic [3:0]  dig_h;
    logic        dash;
    logic [7:0]  chr_h;
    logic [7:0]  chr_t;
    logic [7:0]  chr_u;

    assign in_cmd  = cmd_t'(s_tuser);
    assign in_rev  = s_tdata[15:0];
    assign in_time = s_tdata[31:16];
    assign in_link = s_tdata[32];

    assign s_tready  = state_reg == ST_IDLE;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Iterative divider for the cadence quotient
    ccd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_reg),
        .den   (dt_reg),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // One divide-by-ten constant multiplier, stepped down the digit chain
    always_comb
    begin
        case (state_reg)
            ST_DIG_B: d10_in = {3'b000, qa_reg};
            ST_DIG_C: d10_in = {6'b000000, qb_reg};
            default:  d10_in = cadence_reg;
        endcase
    end

    assign d10_out = div10(d10_in);

    // Digits from value minus ten times quotient; nibble math is exact below ten
    assign dig_u = rem10(cadence_reg[3:0], qa_reg[3:0]);
    assign dig_t = rem10(qa_reg[3:0], qb_reg[3:0]);
    assign dig_h = rem10(qb_reg[3:0], qc_reg[3:0]);

    // Dash on implausible cadence, link down, or no revolution within the timeout
    assign dash = (cadence_reg > {6'b000000, max_cad_reg}) || !link_reg ||
                  (ms_reg > stale_reg);

    always_comb
    begin
        if (dash)
        begin
            chr_h = CHR_DASH;
            chr_t = CHR_DASH;
            chr_u = CHR_DASH;
        end
        else
        begin
            chr_h = (cadence_reg < HUNDRED) ? CHR_SPACE : (CHR_ZERO | {4'b0000, dig_h});
            chr_t = CHR_ZERO | {4'b0000, dig_t};
            chr_u = CHR_ZERO | {4'b0000, dig_u};
        end
    end

    // Register writes; the user must issue them only while no word is in flight (not enforced)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tups_reg    <= TUPS_RESET;
            max_cad_reg <= MAX_CAD_RESET;
            stale_reg   <= STALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TUPS:    tups_reg    <= cfg_data;
                CFG_MAX_CAD: max_cad_reg <= cfg_data[9:0];
                CFG_STALE:   stale_reg   <= cfg_data;
                CFG_NONE:    ;
                default:     ;
            endcase
        end
    end

    // Sequencer, tracked state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_count_reg <= '0;
            last_time_reg  <= '0;
            cadence_reg    <= CADENCE_RESET;
            ms_reg         <= '0;
            link_reg       <= 1'b0;
            dc_reg         <= '0;
            dt_reg         <= '0;
            scaled_reg     <= '0;
            num_reg        <= '0;
            div_start_reg  <= 1'b0;
            qa_reg         <= '0;
            qb_reg         <= '0;
            qc_reg         <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= 1'b0;
        end
        else
        begin
            // drop the result once taken; the emit state handles its own load
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // pulse the divider start right after the numerator is formed
            div_start_reg <= state_reg == ST_MUL_B;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        // same count as stored: nothing changes, go straight to digits
                        if (in_cmd == CMD_MEAS && in_rev != last_count_reg)
                        begin
                            state_reg <= ST_MUL_A;
                        end
                        else
                        begin
                            state_reg <= ST_DIG_A;
                        end
                        case (in_cmd)
                            CMD_MEAS:
                            begin
                                if (in_rev != last_count_reg)
                                begin
                                    dc_reg         <= in_rev - last_count_reg;
                                    dt_reg         <= in_time - last_time_reg;
                                    last_count_reg <= in_rev;
                                    last_time_reg  <= in_time;
                                    ms_reg         <= '0;
                                end
                            end
                            CMD_TICK:
                            begin
                                if (ms_reg != MS_SAT)
                                begin
                                    ms_reg <= ms_reg + 16'd1;
                                end
                            end
                            CMD_LINK:
                            begin
                                link_reg <= in_link;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL_A:
                begin
                    // 60 * units = 64 * units - 4 * units
                    scaled_reg <= {tups_reg, 6'b000000} - {4'b0000, tups_reg, 2'b00};
                    state_reg  <= ST_MUL_B;
                end
                ST_MUL_B:
                begin
                    num_reg   <= scaled_reg * dc_reg;
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        cadence_reg <= div_quot;
                        state_reg   <= ST_DIG_A;
                    end
                end
                ST_DIG_A:
                begin
                    qa_reg    <= d10_out;
                    state_reg <= ST_DIG_B;
                end
                ST_DIG_B:
                begin
                    qb_reg    <= d10_out[9:0];
                    state_reg <= ST_DIG_C;
                end
                ST_DIG_C:
                begin
                    qc_reg    <= d10_out[6:0];
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    // hold here while the previous result still waits
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {cadence_reg, chr_u, chr_t, chr_h};
                        m_tuser_reg  <= dash;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_dash_chars: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[23:0] == {CHR_DASH, CHR_DASH, CHR_DASH})
        else $error("dash flag without three dash characters");

    a_shown_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[39:24] <= {6'b000000, max_cad_reg})
        else $error("digits shown for cadence above maximum");

    a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !s_tready)
        else $error("input ready while divider runs");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> !div_stat.busy && state_reg == ST_DIV_WAIT)
        else $error("divider started while busy");

endmodule

`default_nettype wire

### rtl/core/ccd_div.sv
// Iterative restoring divider: 38-bit numerator by 16-bit divisor, 16-bit
// quotient saturating at all ones. Depends on ccd_pkg.
`default_nettype none

module ccd_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ccd_pkg::NUM_W-1:0] num,
    input  wire logic [15:0]               den,
    output logic [15:0]                    quot,
    output ccd_pkg::div_stat_t             stat
);
    import ccd_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_DONE
    } dstate_t;

    dstate_t     state_reg;
    logic [15:0] den_reg;
    logic [15:0] rem_reg;
    logic [15:0] lo_reg;
    logic [15:0] quot_reg;
    logic [3:0]  cnt_reg;

    logic [16:0] part;
    logic        ge;
    logic [16:0] diff;

    // One quotient bit per cycle
    assign part = {rem_reg, lo_reg[15]};
    assign ge   = part >= {1'b0, den_reg};
    assign diff = part - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            den_reg   <= '0;
            rem_reg   <= '0;
            lo_reg    <= '0;
            quot_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        den_reg <= den;
                        lo_reg  <= num[15:0];
                        cnt_reg <= 4'd15;
                        // high part not below the divisor: quotient overflows 16 bits
                        if (num[NUM_W-1:16] >= {{(NUM_W-32){1'b0}}, den})
                        begin
                            quot_reg  <= CADENCE_SAT;
                            state_reg <= D_DONE;
                        end
                        else
                        begin
                            rem_reg   <= num[31:16];
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg  <= ge ? diff[15:0] : part[15:0];
                    lo_reg   <= {lo_reg[14:0], 1'b0};
                    quot_reg <= {quot_reg[14:0], ge};
                    cnt_reg  <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0)
                    begin
                        state_reg <= D_DONE;
                    end
                end
                D_DONE:
                begin
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = state_reg != D_IDLE;
    assign stat.done = state_reg == D_DONE;

endmodule

`default_nettype wire
